FILE: src/rth_pkg.sv
// Shared types and constants for the RGB to HSL converter.
`timescale 1ns / 1ps

package rth_pkg;

    // Numerator width of both dividers; both numerators stay below 2**24.
    localparam int RTH_NUM_W = 24;
    // Reciprocal table: floor(2**RTH_RECIP_SHIFT / d), needs one more bit for d = 1.
    localparam int RTH_RECIP_SHIFT = 24;
    localparam int RTH_RECIP_W = RTH_RECIP_SHIFT + 1;
    localparam int RTH_PROD_W = RTH_NUM_W + RTH_RECIP_W;
    // Quotient width: saturation can reach 65536 before clamping.
    localparam int RTH_QUOT_W = 17;
    localparam int RTH_DIV_W = 8;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rth_pixel_t;

    typedef struct packed {
        logic [14:0] hue;
        logic [15:0] saturation;
        logic [8:0]  lightness_sum;
    } rth_hsl_t;

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic front;
        logic recip;
        logic mult;
        logic fix;
    } rth_stage_en_t;

    // Results of the first stage.
    typedef struct packed {
        logic        gray;
        logic [8:0]  sum;
        logic [7:0]  diff;
        logic [7:0]  den;
        logic [10:0] num;
    } rth_front_t;

endpackage

FILE: src/rth_front.sv
// First pipeline stage: min, max, lightness sum, hue sector numerator and saturation divisor.
`timescale 1ns / 1ps

module rth_front (
    input  logic               aclk,
    input  rth_pkg::rth_stage_en_t en,
    input  rth_pkg::rth_pixel_t    pix,
    output rth_pkg::rth_front_t    front
);
    import rth_pkg::*;

    localparam logic [8:0] LightSplit = 9'd255;
    localparam logic [8:0] LightFull  = 9'd510;

    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [8:0]  sum;
    logic [8:0]  den_hi;
    logic [7:0]  diff;
    logic [11:0] d12;
    logic [11:0] three_d;
    logic [11:0] five_d;
    logic [11:0] six_d;
    logic [11:0] raw_num;
    logic [11:0] wrap_num;
    logic [11:0] r12;
    logic [11:0] g12;
    logic [11:0] b12;
    rth_front_t  front_next;
    rth_front_t  front_reg;

    always_comb begin
        lo = (pix.red < pix.green) ? pix.red : pix.green;
        lo = (lo < pix.blue) ? lo : pix.blue;
        hi = (pix.red > pix.green) ? pix.red : pix.green;
        hi = (hi > pix.blue) ? hi : pix.blue;
        sum  = {1'b0, lo} + {1'b0, hi};
        diff = hi - lo;

        r12 = {4'b0, pix.red};
        g12 = {4'b0, pix.green};
        b12 = {4'b0, pix.blue};
        d12 = {4'b0, diff};
        three_d = (d12 << 1) + d12;
        five_d  = (d12 << 2) + d12;
        six_d   = (d12 << 2) + (d12 << 1);

        // Red wins a tied minimum over green and blue, green wins over blue.
        if (pix.red == lo) begin
            raw_num = three_d + b12 - g12;
        end else if (pix.green == lo) begin
            raw_num = five_d + r12 - b12;
        end else begin
            raw_num = d12 + g12 - r12;
        end
        wrap_num = (raw_num >= six_d) ? (raw_num - six_d) : raw_num;

        den_hi = LightFull - sum;

        front_next.gray = (diff == 8'd0);
        front_next.sum  = sum;
        front_next.diff = diff;
        front_next.den  = (sum <= LightSplit) ? sum[7:0] : den_hi[7:0];
        front_next.num  = wrap_num[10:0];
    end

    always_ff @(posedge aclk) begin
        if (en.front) begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

FILE: src/rth_div.sv
// Three-stage divider: reciprocal lookup, estimate multiply, remainder correction.
`timescale 1ns / 1ps

module rth_div (
    input  logic                              aclk,
    input  rth_pkg::rth_stage_en_t            en,
    input  logic [rth_pkg::RTH_NUM_W-1:0]     num_in,
    input  logic [rth_pkg::RTH_DIV_W-1:0]     div_in,
    output logic [rth_pkg::RTH_QUOT_W-1:0]    quot
);
    import rth_pkg::*;

    localparam int unsigned RecipOne = 32'd1 << RTH_RECIP_SHIFT;
    localparam int TabDepth = 1 << RTH_DIV_W;

    logic [RTH_RECIP_W-1:0] recip_tab [TabDepth];

    // Reciprocal table; a zero divisor reads zero and its quotient is discarded.
    assign recip_tab[0] = '0;
    for (genvar Dv = 1; Dv < TabDepth; Dv++) begin : g_recip
        localparam int unsigned RecipVal = RecipOne / Dv;
        assign recip_tab[Dv] = RTH_RECIP_W'(RecipVal);
    end

    logic [RTH_NUM_W-1:0]   num_a_reg;
    logic [RTH_DIV_W-1:0]   div_a_reg;
    logic [RTH_RECIP_W-1:0] recip_a_reg;

    logic [RTH_PROD_W-1:0]  prod_b;
    logic [RTH_QUOT_W-1:0]  est_b_next;
    logic [RTH_QUOT_W-1:0]  est_b_reg;
    logic [RTH_NUM_W-1:0]   num_b_reg;
    logic [RTH_DIV_W-1:0]   div_b_reg;

    logic [RTH_QUOT_W+RTH_DIV_W-1:0] back_c;
    logic [RTH_QUOT_W+RTH_DIV_W-1:0] rem_c;
    logic                            bump_c;
    logic [RTH_QUOT_W-1:0]           quot_c_next;
    logic [RTH_QUOT_W-1:0]           quot_c_reg;

    always_ff @(posedge aclk) begin
        if (en.recip) begin
            num_a_reg   <= num_in;
            div_a_reg   <= div_in;
            recip_a_reg <= recip_tab[div_in];
        end
    end

    // The floor reciprocal undershoots the true quotient by at most one.
    always_comb begin
        prod_b     = {{RTH_RECIP_W{1'b0}}, num_a_reg} * {{RTH_NUM_W{1'b0}}, recip_a_reg};
        est_b_next = prod_b[RTH_RECIP_SHIFT +: RTH_QUOT_W];
    end

    always_ff @(posedge aclk) begin
        if (en.mult) begin
            est_b_reg <= est_b_next;
            num_b_reg <= num_a_reg;
            div_b_reg <= div_a_reg;
        end
    end

    always_comb begin
        back_c = {{RTH_DIV_W{1'b0}}, est_b_reg} * {{RTH_QUOT_W{1'b0}}, div_b_reg};
        rem_c  = {{(RTH_QUOT_W+RTH_DIV_W-RTH_NUM_W){1'b0}}, num_b_reg} - back_c;
        bump_c = (rem_c >= {{RTH_QUOT_W{1'b0}}, div_b_reg});
        quot_c_next = est_b_reg + {{(RTH_QUOT_W-1){1'b0}}, bump_c};
    end

    always_ff @(posedge aclk) begin
        if (en.fix) begin
            quot_c_reg <= quot_c_next;
        end
    end

    assign quot = quot_c_reg;

endmodule

FILE: src/rth_out.sv
// Output register with a skid stage, so the pipeline's ready does not depend on m_ready.
`timescale 1ns / 1ps

module rth_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  rth_pkg::rth_hsl_t in_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rth_pkg::rth_hsl_t m_data
);
    import rth_pkg::*;

    logic     out_valid_reg;
    logic     out_valid_next;
    logic     skid_valid_reg;
    logic     skid_valid_next;
    rth_hsl_t out_data_reg;
    rth_hsl_t out_data_next;
    rth_hsl_t skid_data_reg;
    rth_hsl_t skid_data_next;

    assign in_ready = !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: src/rgb_to_hsl.sv
// Top level of the RGB to HSL converter: pipeline control, dividers and result assembly.
`timescale 1ns / 1ps

//  Channel | Ports                     | Transfer payload
//  --------+---------------------------+----------------------------------------------
//  input   | s_valid, s_ready, s_data  | red, green, blue (8 bits each)
//  result  | m_valid, m_ready, m_data  | hue (1/64 deg), saturation (Q0.16), lightness_sum
//
//  One pixel is taken in every cycle while s_ready is high, and each pixel gives exactly one result.
//  Before m_valid rises, the pixel passes four pipeline stages (first stage,
//  reciprocal lookup, estimate multiply, remainder correction) and the output
//  register, and the first stage loads at the input transfer edge.
//  The synchronous active-low reset clears only valid bits.
//  When m_ready is low the skid stage catches one result, then the stages stall
//  from the back to the front, and s_ready falls only when the first stage is
//  full and cannot move on.

module rgb_to_hsl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rth_pkg::rth_pixel_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rth_pkg::rth_hsl_t   m_data
);
    import rth_pkg::*;

    localparam logic [14:0] HueMax = 15'd23039;

    rth_stage_en_t en;
    rth_front_t    front;

    // Valid bits of the four pipeline stages.
    logic front_valid_reg;
    logic recip_valid_reg;
    logic mult_valid_reg;
    logic fix_valid_reg;

    // Gray flag and lightness sum travel beside the dividers.
    logic       gray_a_reg;
    logic       gray_b_reg;
    logic       gray_c_reg;
    logic [8:0] sum_a_reg;
    logic [8:0] sum_b_reg;
    logic [8:0] sum_c_reg;

    logic [RTH_NUM_W-1:0]  hue_num;
    logic [RTH_NUM_W-1:0]  sat_num;
    logic [RTH_QUOT_W-1:0] hue_quot;
    logic [RTH_QUOT_W-1:0] sat_quot;
    logic                  out_ready;
    rth_hsl_t              result;

    // A stage loads when it is empty or when the stage after it loads too.
    always_comb begin
        en.fix   = !fix_valid_reg || out_ready;
        en.mult  = !mult_valid_reg || en.fix;
        en.recip = !recip_valid_reg || en.mult;
        en.front = !front_valid_reg || en.recip;
    end

    assign s_ready = en.front;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
            recip_valid_reg <= 1'b0;
            mult_valid_reg  <= 1'b0;
            fix_valid_reg   <= 1'b0;
        end else begin
            if (en.front) begin
                front_valid_reg <= s_valid;
            end
            if (en.recip) begin
                recip_valid_reg <= front_valid_reg;
            end
            if (en.mult) begin
                mult_valid_reg <= recip_valid_reg;
            end
            if (en.fix) begin
                fix_valid_reg <= mult_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.recip) begin
            gray_a_reg <= front.gray;
            sum_a_reg  <= front.sum;
        end
        if (en.mult) begin
            gray_b_reg <= gray_a_reg;
            sum_b_reg  <= sum_a_reg;
        end
        if (en.fix) begin
            gray_c_reg <= gray_b_reg;
            sum_c_reg  <= sum_b_reg;
        end
    end

    rth_front u_front (
        .aclk  (aclk),
        .en    (en),
        .pix   (s_data),
        .front (front)
    );

    // Hue numerator is 3840 times the sector numerator (60 degrees in 1/64 steps);
    // the saturation numerator is the difference scaled by 2**16.
    assign hue_num = {1'b0, front.num, 12'b0} - {5'b0, front.num, 8'b0};
    assign sat_num = {front.diff, 16'b0};

    rth_div u_hue_div (
        .aclk   (aclk),
        .en     (en),
        .num_in (hue_num),
        .div_in (front.diff),
        .quot   (hue_quot)
    );

    rth_div u_sat_div (
        .aclk   (aclk),
        .en     (en),
        .num_in (sat_num),
        .div_in (front.den),
        .quot   (sat_quot)
    );

    // Gray pixels report zero hue and saturation; a full saturation of 1.0
    // would need bit 16 and is clamped to the largest Q0.16 code.
    always_comb begin
        result.lightness_sum = sum_c_reg;
        if (gray_c_reg) begin
            result.hue        = '0;
            result.saturation = '0;
        end else begin
            result.hue        = hue_quot[14:0];
            result.saturation = sat_quot[16] ? 16'hFFFF : sat_quot[15:0];
        end
    end

    rth_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fix_valid_reg),
        .in_ready (out_ready),
        .in_data  (result),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef SYNTHESIS
    // The divider correction must keep every hue below 360 degrees.
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.hue <= HueMax))
        else $error("hue result out of range");

    // A pixel with a nonzero hue is not gray, so its saturation cannot be zero.
    a_chroma: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.hue != '0)) |-> (m_data.saturation != '0))
        else $error("nonzero hue with zero saturation");

    // A result held back by the output stage keeps its valid bit and quotients.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (fix_valid_reg && !out_ready) |=>
            (fix_valid_reg && $stable(hue_quot) && $stable(sat_quot)))
        else $error("stalled result lost or changed");

    // The input side is refused only while the first stage holds a pixel.
    a_refuse_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> front_valid_reg)
        else $error("input refused with an empty first stage");
`endif

endmodule

FILE: dv/rth_checker.sv
// Checker for the RGB to HSL converter: predicts each result and compares it on the output channel.
`timescale 1ns / 1ps

module rth_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  rth_pkg::rth_pixel_t s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  rth_pkg::rth_hsl_t   m_data,
    output int                  mismatch_count,
    output int                  hsl_in_flight
);
    import rth_pkg::*;

    typedef struct {
        rth_pixel_t pixel;
        rth_hsl_t   hsl;
    } hsl_entry_t;

    hsl_entry_t expected_hsl[$];
    int         error_total = 0;

    // Integer form of the conversion: hue in 1/64 degree, saturation in Q0.16.
    function automatic rth_hsl_t predict_hsl(rth_pixel_t px);
        int unsigned r, g, b, lo, hi, d, num, den, q;
        rth_hsl_t    res;
        r = 32'(px.red);
        g = 32'(px.green);
        b = 32'(px.blue);
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        d = hi - lo;
        res.lightness_sum = 9'(lo + hi);
        res.hue = '0;
        res.saturation = '0;
        if (d != 0) begin
            // Sector offset picked by the minimum channel, red first, then green.
            if (r == lo) begin
                num = 3 * d + b - g;
            end else if (g == lo) begin
                num = 5 * d + r - b;
            end else begin
                num = d + g - r;
            end
            if (num >= 6 * d) begin
                num = num - 6 * d;
            end
            res.hue = 15'((3840 * num) / d);
            den = (lo + hi <= 255) ? (lo + hi) : (510 - lo - hi);
            q = (d << 16) / den;
            res.saturation = (q > 65535) ? 16'hFFFF : 16'(q);
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, rth_pixel_t px, int got, int want);
        $display("[%0t] %s: rgb=(%0d,%0d,%0d) got %0d, want %0d",
                 $realtime, what, px.red, px.green, px.blue, got, want);
        error_total++;
    endtask

    always @(posedge aclk) begin
        hsl_entry_t oldest;
        if (!aresetn) begin
            expected_hsl.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_hsl.size() == 0) begin
                    report_mismatch("result with nothing pending", '0, int'(m_data.hue), 0);
                end else begin
                    oldest = expected_hsl.pop_front();
                    if (m_data.hue !== oldest.hsl.hue)
                        report_mismatch("hue", oldest.pixel, int'(m_data.hue),
                                        int'(oldest.hsl.hue));
                    if (m_data.saturation !== oldest.hsl.saturation)
                        report_mismatch("saturation", oldest.pixel, int'(m_data.saturation),
                                        int'(oldest.hsl.saturation));
                    if (m_data.lightness_sum !== oldest.hsl.lightness_sum)
                        report_mismatch("lightness_sum", oldest.pixel,
                                        int'(m_data.lightness_sum),
                                        int'(oldest.hsl.lightness_sum));
                end
            end
            if (s_valid && s_ready) begin
                expected_hsl.push_back('{pixel: s_data, hsl: predict_hsl(s_data)});
            end
        end
        mismatch_count <= error_total;
        hsl_in_flight <= expected_hsl.size();
    end

endmodule

FILE: dv/tb_rgb_to_hsl.sv
// Testbench top for the RGB to HSL converter: clock, reset, pixel stimulus, result stalls, verdict.
`timescale 1ns / 1ps

module tb_rgb_to_hsl;
    import rth_pkg::*;

    // Cycles in a row with no transfer on either channel before the run is abandoned.
    // The slowest correct stretch is a sender gap plus a receiver stall plus the
    // trip through the pipeline, so this is far above anything a working block needs.
    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PER_BLOCK = 275;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    rth_pixel_t s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    rth_hsl_t   m_data;

    int mismatch_count;
    int hsl_in_flight;

    // When set, neither side inserts gaps, so the pipeline runs at full rate.
    bit calm = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    rgb_to_hsl uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    rth_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .hsl_in_flight  (hsl_in_flight)
    );

    // Offers one pixel after a random gap and returns at the edge where the
    // transfer happens. With no gap, valid simply stays high for the next pixel.
    task automatic send_pixel(rth_pixel_t px);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Holds the input side idle until every pending result has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (hsl_in_flight != 0) @(posedge aclk);
    endtask

    // Pixel stimulus: corner cases first, then random blocks with a drain between them.
    initial begin
        logic [23:0] corner_pixels [22] = '{
            24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffff00,
            24'h00ffff, 24'hff00ff, 24'h0a0ac8, 24'h643232, 24'h323232, 24'h808080,
            24'h80807f, 24'h7f8080, 24'h807f7f, 24'h010000, 24'h000001, 24'hc83232,
            24'hc83233, 24'h01fe80, 24'h3264c8, 24'hfe01ff
        };
        logic [7:0] edge_vals [4] = '{8'd0, 8'd1, 8'd254, 8'd255};
        rth_pixel_t  px;
        int unsigned kind;
        logic [7:0]  shade;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Corner pixels: primaries, gray, tied minimums, the sum = 255 boundary
        // for the saturation divisor, full saturation and the hue wrap at 360.
        foreach (corner_pixels[k]) begin
            send_pixel(rth_pixel_t'(corner_pixels[k]));
        end
        // Drain: the sender waits until every result is out.
        drain_results();

        for (int blk = 0; blk < 4; blk++) begin
            for (int k = 0; k < ITEMS_PER_BLOCK; k++) begin
                // Full-rate stretches: one whole block and the tail of every fifty items.
                calm = (blk == 2) || (k % 50 >= 40);
                kind = $urandom_range(0, 19);
                px.red = 8'($urandom);
                px.green = 8'($urandom);
                px.blue = 8'($urandom);
                if (kind >= 14 && kind <= 16) begin
                    // Two channels tied, which exercises the minimum priority order.
                    shade = 8'($urandom);
                    case (kind)
                        14: begin
                            px.red = shade;
                            px.green = shade;
                        end
                        15: begin
                            px.green = shade;
                            px.blue = shade;
                        end
                        default: begin
                            px.red = shade;
                            px.blue = shade;
                        end
                    endcase
                end else if (kind == 17) begin
                    px.green = px.red;
                    px.blue = px.red;
                end else if (kind >= 18) begin
                    px.red = edge_vals[$urandom_range(0, 3)];
                    px.green = edge_vals[$urandom_range(0, 3)];
                    px.blue = edge_vals[$urandom_range(0, 3)];
                end
                send_pixel(px);
            end
            calm = 1'b0;
            drain_results();
        end

        // This wait past the last drain catches any stray result before the verdict.
        repeat (12) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("rgb_to_hsl: match");
        end else begin
            $display("rgb_to_hsl: mismatch");
        end
        $finish;
    end

    // Result side: each result waits out a random stall before ready goes high.
    initial begin
        int unsigned stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Watchdog: a run that stops moving on both channels is a failure.
    always @(posedge aclk) begin
        int idle_cycles;
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("rgb_to_hsl: mismatch");
            $finish;
        end
    end

endmodule
